// File: hdl/nhps_pkg.sv
package nhps_pkg;

  // character codes seen on the serial line
  localparam logic [7:0] CharDollar  = 8'h24;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharVtab    = 8'h0B;
  localparam logic [7:0] CharFfeed   = 8'h0C;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;

  // heading field occupies character positions 7 to 9
  localparam logic [3:0] FieldFirst = 4'd7;
  localparam logic [3:0] FieldEnd   = 4'd10;

  // wrap limits and magnitude ceiling
  localparam logic signed [11:0] WrapFull = 12'sd360;
  localparam logic signed [11:0] WrapHalf = 12'sd180;
  localparam logic [8:0]         MagMax   = 9'd511;

  // configuration register indexes
  localparam logic CfgOldWeight = 1'b0;
  localparam logic CfgNewWeight = 1'b1;

  localparam logic [8:0] WeightReset = 9'd128;

  // wrapped heading handed from the parser to the blend pipeline
  typedef struct packed {
    logic       neg;
    logic [9:0] mag;
  } hdg_t;

endpackage

// File: hdl/nhps_parse.sv
module nhps_parse
  import nhps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] byte_i,
  input  logic       byte_vld_i,
  output logic       byte_rdy_o,
  output hdg_t       hdg_o,
  output logic       hdg_vld_o,
  input  logic       hdg_rdy_i
);

  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhDone   = 2'd2;

  logic       in_sent_q, in_sent_d;
  logic [3:0] pos_q, pos_d;
  logic [1:0] phase_q, phase_d;
  logic       neg_q, neg_d;
  logic [9:0] val_q, val_d;
  logic       hvld_q, hvld_d;
  hdg_t       hdg_q, hdg_d;

  logic             accept;
  logic             is_blank, is_digit;
  logic [3:0]       pos_n;
  logic [9:0]       digit;
  logic signed [11:0] h0, h1, h2;

  assign byte_rdy_o = !hvld_q || hdg_rdy_i;
  assign accept     = byte_vld_i && byte_rdy_o;

  assign is_blank = byte_i inside {CharSpace, CharTab, CharVtab, CharFfeed, CharCr};
  assign is_digit = (byte_i >= CharZero) && (byte_i <= CharNine);
  assign digit    = {2'b00, byte_i - CharZero};
  assign pos_n    = (pos_q < FieldEnd) ? pos_q + 4'd1 : pos_q;

  // wrap the parsed value into the heading range
  always_comb begin
    h0 = neg_q ? -$signed({2'b00, val_q}) : $signed({2'b00, val_q});
    h1 = (h0 > WrapFull) ? h0 - WrapFull : h0;
    h2 = (h1 > WrapHalf) ? h1 - WrapFull : h1;
  end

  // parser state and wrapped-heading stage
  always_comb begin
    in_sent_d = in_sent_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    neg_d     = neg_q;
    val_d     = val_q;
    hvld_d    = hvld_q && !hdg_rdy_i;
    hdg_d     = hdg_q;
    if (accept) begin
      if (byte_i == CharDollar) begin
        in_sent_d = 1'b1;
        pos_d     = '0;
        phase_d   = PhSkip;
        neg_d     = 1'b0;
        val_d     = '0;
      end else if (byte_i == CharNewline) begin
        if (in_sent_q) begin
          in_sent_d = 1'b0;
          hvld_d    = 1'b1;
          hdg_d.neg = h2 < 0;
          hdg_d.mag = (h2 < 0) ? 10'(-h2) : 10'(h2);
        end
      end else if (in_sent_q) begin
        pos_d = pos_n;
        if (pos_n >= FieldFirst && pos_n < FieldEnd) begin
          case (phase_q)
            PhSkip: begin
              if (!is_blank) begin
                if (byte_i == CharMinus || byte_i == CharPlus) begin
                  neg_d   = byte_i == CharMinus;
                  phase_d = PhDigits;
                end else if (is_digit) begin
                  val_d   = digit;
                  phase_d = PhDigits;
                end else begin
                  phase_d = PhDone;
                end
              end
            end
            PhDigits: begin
              if (is_digit) begin
                val_d = (val_q << 3) + (val_q << 1) + digit;
              end else begin
                phase_d = PhDone;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      pos_q     <= '0;
      phase_q   <= PhSkip;
      neg_q     <= 1'b0;
      val_q     <= '0;
      hvld_q    <= 1'b0;
    end else begin
      in_sent_q <= in_sent_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      neg_q     <= neg_d;
      val_q     <= val_d;
      hvld_q    <= hvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdg_q <= hdg_d;
  end

  assign hdg_o     = hdg_q;
  assign hdg_vld_o = hvld_q;

endmodule

// File: hdl/nhps_blend.sv
module nhps_blend
  import nhps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [8:0] old_weight_i,
  input  logic [8:0] new_weight_i,
  input  hdg_t       hdg_i,
  input  logic       hdg_vld_i,
  output logic       hdg_rdy_o,
  output logic [9:0] heading_o,
  output logic       heading_vld_o,
  input  logic       heading_rdy_i
);

  logic        bvld_q, bvld_d;
  logic        bneg_q;
  logic [18:0] bprod_q;
  logic        ovld_q, ovld_d;
  logic [9:0]  odata_q;
  logic [8:0]  last_mag_q;

  logic        out_free, b_free;
  logic [17:0] prod_old;
  logic [19:0] sum;
  logic [11:0] scaled;
  logic [8:0]  mag;
  logic [9:0]  res;

  assign out_free  = !ovld_q || heading_rdy_i;
  assign b_free    = !bvld_q || out_free;
  assign hdg_rdy_o = b_free;

  // weighted sum of last and new magnitudes, saturated, sign restored
  always_comb begin
    prod_old = 18'(old_weight_i) * 18'(last_mag_q);
    sum      = 20'(prod_old) + 20'(bprod_q);
    scaled   = sum[19:8];
    mag      = (scaled > 12'(MagMax)) ? MagMax : scaled[8:0];
    res      = bneg_q ? -{1'b0, mag} : {1'b0, mag};
  end

  always_comb begin
    bvld_d = b_free ? hdg_vld_i : bvld_q;
    ovld_d = out_free ? bvld_q : ovld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q     <= 1'b0;
      ovld_q     <= 1'b0;
      last_mag_q <= '0;
    end else begin
      bvld_q <= bvld_d;
      ovld_q <= ovld_d;
      if (out_free && bvld_q) begin
        last_mag_q <= mag;
      end
    end
  end

  // new-weight product stage and result register
  always_ff @(posedge clk_i) begin
    if (b_free && hdg_vld_i) begin
      bneg_q  <= hdg_i.neg;
      bprod_q <= 19'(new_weight_i) * 19'(hdg_i.mag);
    end
    if (out_free && bvld_q) begin
      odata_q <= res;
    end
  end

  assign heading_o     = odata_q;
  assign heading_vld_o = ovld_q;

endmodule

// File: hdl/nmea_heading_parse_smooth.sv
// channel   dir  tdata fields (low bit up)   tuser  tlast
// s_axis    in   rx_byte[7:0]                 -      -
// m_axis    out  heading_deg[9:0], pad[15:10] -      -
// cfg       in   index 0 old_weight, 1 new_weight, data[8:0]
//
// one byte is taken per cycle, with no gaps, unless a stalled heading holds
// the parser; the parser updates its state in the cycle of the transfer
// a sentence end is offered as a heading once its newline transfer has
// passed the wrap stage, loaded at the transfer edge, then the new-weight
// product stage, then old-weight sum into the result register
// a stalled result holds in its register while upstream stages keep filling
// reset clears the parser, the stored heading and both weights to 128
module nmea_heading_parse_smooth
  import nhps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // heading_deg[9:0], zeros[15:10]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  logic [8:0] old_weight_q, new_weight_q;
  hdg_t       hdg;
  logic       hdg_vld, hdg_rdy;
  logic [9:0] heading;

  // weight registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_weight_q <= WeightReset;
      new_weight_q <= WeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOldWeight: old_weight_q <= cfg_wdata_i;
        CfgNewWeight: new_weight_q <= cfg_wdata_i;
        default:      old_weight_q <= old_weight_q;
      endcase
    end
  end

  nhps_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (s_axis_tdata),
    .byte_vld_i (s_axis_tvalid),
    .byte_rdy_o (s_axis_tready),
    .hdg_o      (hdg),
    .hdg_vld_o  (hdg_vld),
    .hdg_rdy_i  (hdg_rdy)
  );

  nhps_blend u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .old_weight_i  (old_weight_q),
    .new_weight_i  (new_weight_q),
    .hdg_i         (hdg),
    .hdg_vld_i     (hdg_vld),
    .hdg_rdy_o     (hdg_rdy),
    .heading_o     (heading),
    .heading_vld_o (m_axis_tvalid),
    .heading_rdy_i (m_axis_tready)
  );

  assign m_axis_tdata = {6'b000000, heading};

endmodule

// File: hdl/nhps_check.sv
module nhps_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // with the result register empty the whole pipeline drains, so input is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // saturated magnitude keeps the heading inside -511..511 with zero padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0 && m_axis_tdata[9:0] != 10'h200)
    else $error("heading out of range");

  // no result right after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result offered after reset");

endmodule

bind nmea_heading_parse_smooth nhps_check u_check (.*);

// File: test/nmea_heading_parse_smooth_tb.sv
`timescale 1ns / 1ps

module nmea_heading_parse_smooth_tb;
  import nhps_pkg::*;

  localparam int PhaseBytes = 210;
  localparam int HoldCycles = 600;
  localparam int SettleCycles = 6;

  typedef enum logic [1:0] {
    PhSkip,
    PhDigits,
    PhDone
  } field_phase_e;

  // one row of the directed byte sequence
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    int         value;
  } byte_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // heading_deg[9:0], zeros[15:10]
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [8:0]  cfg_wdata_i;

  // parser and smoothing state mirrored from the block
  bit           in_sent;
  int           char_pos;
  field_phase_e phase;
  bit           field_neg;
  int           field_val;
  int           last_hdg;
  int           old_wt;
  int           new_wt;

  logic [9:0] pending_headings[$];
  logic [9:0] want_hdg;
  int         n_errors;
  int         n_sent;
  bit         sender_burst;

  // blank characters skipped ahead of the sign or digits
  logic [7:0] blank_chars[5] = '{CharSpace, CharTab, CharVtab, CharFfeed, CharCr};

  // short directed run at reset weights: newline outside a sentence, the
  // largest field value, a signed field and an empty sentence
  byte_row_t directed_rows[25] = '{
    '{CharNewline, 1'b0, 0},
    '{CharDollar, 1'b0, 0}, '{"H", 1'b0, 0}, '{"C", 1'b0, 0}, '{"H", 1'b0, 0},
    '{"D", 1'b0, 0}, '{"G", 1'b0, 0}, '{",", 1'b0, 0},
    '{"9", 1'b0, 0}, '{"9", 1'b0, 0}, '{"9", 1'b0, 0},
    '{CharNewline, 1'b1, 139},
    '{CharDollar, 1'b0, 0}, '{"H", 1'b0, 0}, '{"C", 1'b0, 0}, '{"H", 1'b0, 0},
    '{"D", 1'b0, 0}, '{"G", 1'b0, 0}, '{",", 1'b0, 0},
    '{CharMinus, 1'b0, 0}, '{"9", 1'b0, 0}, '{"9", 1'b0, 0},
    '{CharNewline, 1'b0, 0},
    '{CharDollar, 1'b0, 0}, '{CharNewline, 1'b0, 0}
  };

  int phase_old[9] = '{128, 0, 256, 511, 0, 256, 511, 0, 0};
  int phase_new[9] = '{128, 256, 0, 511, 0, 256, 0, 511, 0};

  nmea_heading_parse_smooth dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  // advance the parser by one byte; returns 1 with the smoothed heading
  // when the byte closes a started sentence
  function automatic bit predict_heading(input logic [7:0] c, output logic [9:0] hdg);
    int h;
    int last_mag;
    int new_mag;
    int mag;
    hdg = '0;
    if (c == CharDollar) begin
      in_sent = 1'b1;
      char_pos = 0;
      phase = PhSkip;
      field_neg = 1'b0;
      field_val = 0;
      return 1'b0;
    end
    if (c == CharNewline) begin
      if (!in_sent) return 1'b0;
      in_sent = 1'b0;
      h = field_neg ? -field_val : field_val;
      // values up to 900 wrap into -180..180, negative ones stay as read
      if (h > int'(WrapFull)) h -= int'(WrapFull);
      if (h > int'(WrapHalf)) h -= int'(WrapFull);
      last_mag = (last_hdg < 0) ? -last_hdg : last_hdg;
      new_mag = (h < 0) ? -h : h;
      mag = (old_wt * last_mag + new_wt * new_mag) >> 8;
      if (mag > int'(MagMax)) mag = int'(MagMax);
      last_hdg = (h < 0) ? -mag : mag;
      hdg = 10'(last_hdg);
      return 1'b1;
    end
    if (in_sent) begin
      if (char_pos < int'(FieldEnd)) char_pos++;
      if (char_pos >= int'(FieldFirst) && char_pos < int'(FieldEnd)) begin
        // integer read: blanks, one sign, then digits up to a non-digit
        case (phase)
          PhSkip: begin
            if (c inside {CharSpace, CharTab, CharVtab, CharFfeed, CharCr}) begin
            end else if (c == CharMinus || c == CharPlus) begin
              field_neg = (c == CharMinus);
              phase = PhDigits;
            end else if (is_digit(c)) begin
              field_val = int'(c - CharZero);
              phase = PhDigits;
            end else begin
              phase = PhDone;
            end
          end
          PhDigits: begin
            if (is_digit(c)) field_val = field_val * 10 + int'(c - CharZero);
            else phase = PhDone;
          end
          default: begin
          end
        endcase
      end
    end
    return 1'b0;
  endfunction

  // offer one byte after a random gap and record what it should produce
  task automatic send_byte(input logic [7:0] c, input bit typed = 1'b0,
                           input int typed_val = 0);
    int gap;
    logic [9:0] hdg;
    gap = sender_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    if (predict_heading(c, hdg)) pending_headings.push_back(typed ? 10'(typed_val) : hdg);
    n_sent++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharDollar || c == CharNewline);
    return c;
  endfunction

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return CharZero + 8'($urandom_range(0, 9));
    if (r < 14) return blank_chars[$urandom_range(0, 4)];
    if (r == 14) return CharPlus;
    if (r == 15) return CharMinus;
    return plain_char();
  endfunction

  // one sentence, mostly well formed, sometimes short, restarted or unfinished
  task automatic send_sentence();
    int n_noise;
    int n_pre;
    int n_extra;
    sender_burst = ($urandom_range(0, 3) == 0);
    n_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n_noise) send_byte(8'($urandom_range(0, 255)));
    send_byte(CharDollar);
    if ($urandom_range(0, 9) == 0) begin
      n_pre = $urandom_range(0, 8);
      repeat (n_pre) send_byte(plain_char());
      send_byte(CharNewline);
    end else begin
      repeat (6) send_byte(($urandom_range(0, 39) == 0) ? CharDollar : plain_char());
      repeat (3) send_byte(field_char());
      n_extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      repeat (n_extra) send_byte(plain_char());
      if ($urandom_range(0, 19) != 0) send_byte(CharNewline);
    end
  endtask

  // stop offering and wait until every heading is out and the pipe is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_weights(input int w_old, input int w_new);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgOldWeight;
    cfg_wdata_i <= 9'(w_old);
    @(posedge clk_i);
    cfg_idx_i <= CfgNewWeight;
    cfg_wdata_i <= 9'(w_new);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    old_wt = w_old;
    new_wt = w_new;
  endtask

  // stimulus: reset, directed rows, then random phases over weight settings
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgOldWeight;
    cfg_wdata_i = '0;
    in_sent = 1'b0;
    char_pos = 0;
    phase = PhSkip;
    field_neg = 1'b0;
    field_val = 0;
    last_hdg = 0;
    old_wt = int'(WeightReset);
    new_wt = int'(WeightReset);
    n_sent = 0;
    sender_burst = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].value);
    drain();

    phase_old[8] = $urandom_range(0, 511);
    phase_new[8] = $urandom_range(0, 511);
    foreach (phase_old[p]) begin
      set_weights(phase_old[p], phase_new[p]);
      n_sent = 0;
      while (n_sent < PhaseBytes) send_sentence();
      drain();
    end

    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, runs without stalls, one long hold-off
  initial begin
    int gap;
    int n_seen;
    bit fast;
    bit held;
    m_axis_tready = 1'b0;
    n_seen = 0;
    fast = 1'b0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (n_seen % 16 == 0) fast = ($urandom_range(0, 3) == 0);
      gap = fast ? 0 : $urandom_range(0, 9);
      if (!held && n_seen >= 40 && s_axis_tvalid) begin
        held = 1'b1;
        gap = HoldCycles;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      n_seen++;
    end
  end

  // compare each heading transfer with the oldest expected heading
  initial n_errors = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_headings.size() == 0) begin
        $display("%0t: unexpected heading transfer, expected none, got %0d (tdata %h)",
                 $time, $signed(m_axis_tdata[9:0]), m_axis_tdata);
        n_errors++;
      end else begin
        want_hdg = pending_headings.pop_front();
        if (m_axis_tdata != {6'b0, want_hdg}) begin
          $display("%0t: heading expected %0d (tdata %h), got %0d (tdata %h)",
                   $time, $signed(want_hdg), {6'b0, want_hdg},
                   $signed(m_axis_tdata[9:0]), m_axis_tdata);
          n_errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
